// ===== sv/agdrc_pkg.sv =====
// Shared types, constants and tables for the gain, downmix, resample and chunk block.
package agdrc_pkg;

    localparam int MAX_CHANNELS      = 8;
    localparam int MAX_PACKET_FRAMES = 4096;
    localparam int SAMPLE_BITS       = 24;
    localparam int CH_W              = 3;
    localparam int FIP_W             = 13;
    localparam int POS_W             = 29;
    localparam int SUM_W             = 27;
    localparam int RECIP_W           = 31;
    localparam int RECIP_SH          = 30;
    localparam int QUEUE_DEPTH       = 4;

    // Configuration register indexes.
    localparam logic [2:0] REG_CHANNEL_COUNT   = 3'd0;
    localparam logic [2:0] REG_GAIN            = 3'd1;
    localparam logic [2:0] REG_MONO_ENABLE     = 3'd2;
    localparam logic [2:0] REG_RESAMPLE_ENABLE = 3'd3;
    localparam logic [2:0] REG_SOURCE_STEP     = 3'd4;
    localparam logic [2:0] REG_CHUNK_FRAMES    = 3'd5;

    localparam logic [19:0] STEP_MIN = 20'd16384;
    localparam logic [19:0] STEP_MAX = 20'd524288;

    // Configuration with out-of-range values already clamped.
    typedef struct packed {
        logic [3:0]  cc;
        logic [15:0] gain;
        logic        mono;
        logic        resample;
        logic [19:0] step;
        logic [15:0] chunk_len;
        logic [3:0]  nout;
    } cfg_t;

    // One classified sample handed from the front to the back.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] smp;
        logic [CH_W-1:0]        slot;
        logic                   fdone;
        logic                   close;
        logic [FIP_W-1:0]       fipn;
    } q_entry_t;

    // floor(2^30 / n) for the channel counts, used to divide the mono sum.
    function automatic logic [RECIP_W-1:0] recip(input logic [3:0] n);
        logic [RECIP_W-1:0] r;
        unique case (n)
            4'd2:    r = 31'd536870912;
            4'd3:    r = 31'd357913941;
            4'd4:    r = 31'd268435456;
            4'd5:    r = 31'd214748364;
            4'd6:    r = 31'd178956970;
            4'd7:    r = 31'd153391689;
            4'd8:    r = 31'd134217728;
            default: r = 31'd1073741824;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/agdrc_fifo.sv =====
// Short queue of classified samples between the front and the back.
module agdrc_fifo
    import agdrc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_data,
    input  logic     pop,
    output q_entry_t pop_data,
    output logic     full,
    output logic     empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    q_entry_t           mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [PTR_W:0]     count_reg, count_next;

    assign full     = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rptr_reg];

    // Pointer and fill-count update.
    always_comb
    begin
        wptr_next  = wptr_reg + PTR_W'(push);
        rptr_next  = rptr_reg + PTR_W'(pop);
        count_next = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/agdrc_front.sv =====
// Front end: accepts samples, applies gain and classifies frame and packet boundaries.
module agdrc_front
    import agdrc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   in_valid,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    input  logic                   in_last,
    output logic                   in_ready,
    input  logic                   q_full,
    output logic                   q_push,
    output q_entry_t               q_data
);

    logic [CH_W-1:0]  cp_reg, cp_next;
    logic [FIP_W-1:0] fip_reg, fip_next;

    logic signed [40:0] prod;
    logic signed [40:0] rnd;
    logic signed [32:0] shifted;
    logic [SAMPLE_BITS-1:0] gained;
    logic             fdone;
    logic             force_end;
    logic             close;
    logic [FIP_W-1:0] fipn;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // Gain with rounding and saturation.
    always_comb
    begin
        prod    = $signed(in_sample) * $signed({1'b0, cfg.gain});
        rnd     = prod + 41'sd128;
        shifted = 33'(rnd >>> 8);
        if (shifted > 33'sd8388607)
        begin
            gained = 24'h7FFFFF;
        end
        else if (shifted < -33'sd8388608)
        begin
            gained = 24'h800000;
        end
        else
        begin
            gained = shifted[23:0];
        end
    end

    // Frame and packet classification.
    always_comb
    begin
        fdone     = (({1'b0, cp_reg} + 4'd1) >= cfg.cc);
        fipn      = fdone ? fip_reg + 13'd1 : fip_reg;
        force_end = fdone && (fipn >= 13'(MAX_PACKET_FRAMES));
        close     = in_last || force_end;
        cp_next   = cp_reg;
        fip_next  = fip_reg;
        if (q_push)
        begin
            cp_next  = fdone ? '0 : cp_reg + 3'd1;
            fip_next = fipn;
            if (close)
            begin
                cp_next  = '0;
                fip_next = '0;
            end
        end
        q_data.smp   = gained;
        q_data.slot  = cp_reg;
        q_data.fdone = fdone;
        q_data.close = close;
        q_data.fipn  = fipn;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cp_reg  <= '0;
            fip_reg <= '0;
        end
        else
        begin
            cp_reg  <= cp_next;
            fip_reg <= fip_next;
        end
    end

endmodule

// ===== sv/agdrc_back.sv =====
// Back end: downmix, interpolation, chunk marking and result output.
module agdrc_back
    import agdrc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   q_empty,
    input  q_entry_t               q_data,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] out_sample,
    output logic [CH_W-1:0]        out_channel,
    output logic                   out_chunk_end,
    output logic                   out_run_last
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SUM   = 4'd1;
    localparam logic [3:0] ST_DIV1  = 4'd2;
    localparam logic [3:0] ST_DIV2  = 4'd3;
    localparam logic [3:0] ST_FCHK  = 4'd4;
    localparam logic [3:0] ST_EMIT  = 4'd5;
    localparam logic [3:0] ST_POST  = 4'd6;
    localparam logic [3:0] ST_TCHK  = 4'd7;
    localparam logic [3:0] ST_CLOSE = 4'd8;
    localparam logic [3:0] ST_FIN   = 4'd9;

    localparam logic [1:0] MODE_PASS   = 2'd0;
    localparam logic [1:0] MODE_INTERP = 2'd1;
    localparam logic [1:0] MODE_TAIL   = 2'd2;

    logic [3:0]             state_reg, state_next;
    q_entry_t               ent_reg, ent_next;
    logic [SAMPLE_BITS-1:0] gather_reg [MAX_CHANNELS];
    logic [SAMPLE_BITS-1:0] cur_reg    [MAX_CHANNELS];
    logic [SAMPLE_BITS-1:0] prev_reg   [MAX_CHANNELS];
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SUM_W-1:0]       mag_reg, mag_next;
    logic [57:0]            prodd_reg, prodd_next;
    logic                   hp_reg, hp_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [POS_W-1:0]       stop_reg, stop_next;
    logic [1:0]             mode_reg, mode_next;
    logic [CH_W-1:0]        ch_reg, ch_next;
    logic [15:0]            cnt_reg, cnt_next;
    logic                   endf_reg, endf_next;
    logic                   hold_v_reg, hold_v_next;
    logic [SAMPLE_BITS-1:0] hold_s_reg, hold_s_next;
    logic [CH_W-1:0]        hold_c_reg, hold_c_next;
    logic                   hold_e_reg, hold_e_next;
    logic                   o_v_reg, o_v_next;
    logic [SAMPLE_BITS-1:0] o_s_reg, o_s_next;
    logic [CH_W-1:0]        o_c_reg, o_c_next;
    logic                   o_e_reg, o_e_next;
    logic                   o_l_reg, o_l_next;

    logic                   out_free;
    logic                   go;
    logic                   last_ch;
    logic                   end_now;
    logic [SAMPLE_BITS-1:0] val;
    logic signed [24:0]     diff;
    logic signed [41:0]     iprod;
    logic signed [25:0]     ishift;
    logic [SUM_W-1:0]       q0;
    logic [30:0]            qc;
    logic [SUM_W-1:0]       rem;
    logic [SUM_W-1:0]       quo;
    logic [POS_W-1:0]       start;
    logic [POS_W-1:0]       stop;
    logic [POS_W-1:0]       clamped;
    logic [POS_W-1:0]       pos_adv;
    logic signed [SUM_W-1:0] acc;
    logic                   wr_gather;
    logic                   wr_cur_all;
    logic                   wr_cur0;
    logic                   wr_prev;
    logic [SAMPLE_BITS-1:0] cur0_val;

    assign out_valid     = o_v_reg;
    assign out_sample    = o_s_reg;
    assign out_channel   = o_c_reg;
    assign out_chunk_end = o_e_reg;
    assign out_run_last  = o_l_reg;
    assign out_free      = !o_v_reg || out_ready;

    // Result value for the current channel.
    always_comb
    begin
        diff   = $signed({prev_reg[ch_reg][23], prev_reg[ch_reg]}) * 25'sd0
                 + $signed({cur_reg[ch_reg][23], cur_reg[ch_reg]})
                 - $signed({prev_reg[ch_reg][23], prev_reg[ch_reg]});
        iprod  = diff * $signed({1'b0, pos_reg[15:0]});
        ishift = 26'((iprod + 42'sd32768) >>> 16);
        unique case (mode_reg)
            MODE_INTERP: val = prev_reg[ch_reg] + ishift[23:0];
            MODE_TAIL:   val = prev_reg[ch_reg];
            default:     val = cur_reg[ch_reg];
        endcase
    end

    // Mono sum and divide helpers.
    always_comb
    begin
        acc = '0;
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            if (4'(c) < cfg.cc)
            begin
                acc = acc + SUM_W'($signed(gather_reg[c]));
            end
        end
        q0  = prodd_reg[RECIP_SH +: SUM_W];
        qc  = 31'(q0 * cfg.cc);
        rem = mag_reg - qc[SUM_W-1:0];
        quo = (rem >= SUM_W'(cfg.cc)) ? q0 + 27'd1 : q0;
        cur0_val = sum_reg[SUM_W-1] ? 24'(-quo[23:0]) : quo[23:0];
    end

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        ent_next    = ent_reg;
        sum_next    = sum_reg;
        mag_next    = mag_reg;
        prodd_next  = prodd_reg;
        hp_next     = hp_reg;
        pos_next    = pos_reg;
        stop_next   = stop_reg;
        mode_next   = mode_reg;
        ch_next     = ch_reg;
        cnt_next    = cnt_reg;
        endf_next   = endf_reg;
        hold_v_next = hold_v_reg;
        hold_s_next = hold_s_reg;
        hold_c_next = hold_c_reg;
        hold_e_next = hold_e_reg;
        o_v_next    = o_v_reg && !out_ready;
        o_s_next    = o_s_reg;
        o_c_next    = o_c_reg;
        o_e_next    = o_e_reg;
        o_l_next    = o_l_reg;
        q_pop       = 1'b0;
        wr_gather   = 1'b0;
        wr_cur_all  = 1'b0;
        wr_cur0     = 1'b0;
        wr_prev     = 1'b0;
        go          = 1'b0;
        start       = '0;
        stop        = '0;
        clamped     = pos_reg;
        pos_adv     = pos_reg + POS_W'(cfg.step);
        last_ch     = ({1'b0, ch_reg} + 4'd1) == cfg.nout;
        end_now     = (ch_reg == '0) ? (({1'b0, cnt_reg} + 17'd1) >= {1'b0, cfg.chunk_len})
                                     : endf_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    wr_gather  = 1'b1;
                    ent_next   = q_data;
                    if (q_data.fdone)
                    begin
                        state_next = ST_SUM;
                    end
                    else if (q_data.close)
                    begin
                        state_next = ST_TCHK;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SUM:
            begin
                sum_next = acc;
                if (cfg.mono)
                begin
                    state_next = ST_DIV1;
                end
                else
                begin
                    wr_cur_all = 1'b1;
                    state_next = ST_FCHK;
                end
            end
            ST_DIV1:
            begin
                mag_next   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
                prodd_next = 58'((sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg))
                                 * recip(cfg.cc));
                state_next = ST_DIV2;
            end
            ST_DIV2:
            begin
                wr_cur0    = 1'b1;
                state_next = ST_FCHK;
            end
            ST_FCHK:
            begin
                ch_next = '0;
                if (!cfg.resample)
                begin
                    mode_next  = MODE_PASS;
                    state_next = ST_EMIT;
                end
                else if (hp_reg && (ent_reg.fipn > 13'd1))
                begin
                    start     = POS_W'(ent_reg.fipn - 13'd2) << 16;
                    stop      = POS_W'(ent_reg.fipn - 13'd1) << 16;
                    clamped   = (pos_reg < start) ? start : pos_reg;
                    pos_next  = clamped;
                    stop_next = stop;
                    mode_next = MODE_INTERP;
                    state_next = (clamped < stop) ? ST_EMIT : ST_POST;
                end
                else
                begin
                    state_next = ST_POST;
                end
            end
            ST_EMIT:
            begin
                go = !hold_v_reg || out_free;
                if (go)
                begin
                    if (hold_v_reg)
                    begin
                        o_v_next = 1'b1;
                        o_s_next = hold_s_reg;
                        o_c_next = hold_c_reg;
                        o_e_next = hold_e_reg;
                        o_l_next = 1'b0;
                    end
                    hold_v_next = 1'b1;
                    hold_s_next = val;
                    hold_c_next = ch_reg;
                    hold_e_next = end_now && last_ch;
                    if (ch_reg == '0)
                    begin
                        endf_next = end_now;
                        cnt_next  = end_now ? '0 : cnt_reg + 16'd1;
                    end
                    if (!last_ch)
                    begin
                        ch_next = ch_reg + 3'd1;
                    end
                    else
                    begin
                        ch_next = '0;
                        if (mode_reg == MODE_PASS)
                        begin
                            state_next = ST_POST;
                        end
                        else
                        begin
                            pos_next = pos_adv;
                            if (pos_adv >= stop_reg)
                            begin
                                state_next = (mode_reg == MODE_TAIL) ? ST_CLOSE : ST_POST;
                            end
                        end
                    end
                end
            end
            ST_POST:
            begin
                wr_prev    = 1'b1;
                hp_next    = 1'b1;
                state_next = ent_reg.close ? ST_TCHK : ST_FIN;
            end
            ST_TCHK:
            begin
                state_next = ST_CLOSE;
                if (cfg.resample && hp_reg && (ent_reg.fipn != '0))
                begin
                    start     = POS_W'(ent_reg.fipn - 13'd1) << 16;
                    stop      = POS_W'(ent_reg.fipn) << 16;
                    clamped   = (pos_reg < start) ? start : pos_reg;
                    pos_next  = clamped;
                    stop_next = stop;
                    mode_next = MODE_TAIL;
                    ch_next   = '0;
                    if (clamped < stop)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_CLOSE:
            begin
                pos_next   = '0;
                hp_next    = 1'b0;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!hold_v_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    o_v_next    = 1'b1;
                    o_s_next    = hold_s_reg;
                    o_c_next    = hold_c_reg;
                    o_e_next    = hold_e_reg;
                    o_l_next    = 1'b1;
                    hold_v_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            hp_reg     <= 1'b0;
            pos_reg    <= '0;
            cnt_reg    <= '0;
            hold_v_reg <= 1'b0;
            o_v_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            hp_reg     <= hp_next;
            pos_reg    <= pos_next;
            cnt_reg    <= cnt_next;
            hold_v_reg <= hold_v_next;
            o_v_reg    <= o_v_next;
        end
    end

    // Payload and frame storage.
    always_ff @(posedge clk)
    begin
        ent_reg    <= ent_next;
        sum_reg    <= sum_next;
        mag_reg    <= mag_next;
        prodd_reg  <= prodd_next;
        stop_reg   <= stop_next;
        mode_reg   <= mode_next;
        ch_reg     <= ch_next;
        endf_reg   <= endf_next;
        hold_s_reg <= hold_s_next;
        hold_c_reg <= hold_c_next;
        hold_e_reg <= hold_e_next;
        o_s_reg    <= o_s_next;
        o_c_reg    <= o_c_next;
        o_e_reg    <= o_e_next;
        o_l_reg    <= o_l_next;
        if (wr_gather)
        begin
            gather_reg[q_data.slot] <= q_data.smp;
        end
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            if (wr_cur_all)
            begin
                cur_reg[c] <= gather_reg[c];
            end
            if (wr_prev && (4'(c) < cfg.nout))
            begin
                prev_reg[c] <= cur_reg[c];
            end
        end
        if (wr_cur0)
        begin
            cur_reg[0] <= cur0_val;
        end
    end

    // The channel counter stays inside the output frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> ({1'b0, ch_reg} < cfg.nout))
        else $error("channel index beyond output frame width");

    // Closing a packet clears the source position.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLOSE |=> pos_reg == '0)
        else $error("source position not cleared at packet end");

    // An item finishing with nothing held returns straight to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN && !hold_v_reg |=> state_reg == ST_IDLE)
        else $error("sequencer stuck after item end");

    // The held result is only overwritten once it moves to the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && hold_v_reg && !out_free |=> $stable(hold_s_reg))
        else $error("held result lost");

endmodule

// ===== sv/audio_gain_downmix_resample_chunker.sv =====
// Top level: configuration registers, front end, queue and back end.
//
//  Channel   Direction  Handshake             Contents
//  s_axis    in         tvalid/tready         tdata: sample; tlast: packet_end
//  m_axis    out        tvalid/tready         tdata: out_sample; tlast: chunk_end;
//                                             tuser: out_channel, run_last
//  cfg       in         cfg_wen, no wait      cfg_index selects, cfg_data value
//
// The front takes one sample per cycle while its four-entry queue has room.
// The back takes a sample that ends no frame through its idle and finish states. A
// completed frame runs sum, frame check, one emit step per result, post and finish,
// with two divide states more under mono downmix; a packet end adds tail check and
// close. Reset clears all control state; frame storage is not cleared.
// A stalled output holds one result in a hold stage and one in the output register.
module audio_gain_downmix_resample_chunker
    import agdrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [23:0] sample
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // [23:0] out_sample
    output logic        m_axis_tlast,
    output logic [3:0]  m_axis_tuser,  // [2:0] out_channel, [3] run_last
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    logic [3:0]  cc_reg;
    logic [15:0] gain_reg;
    logic        mono_reg;
    logic        resamp_reg;
    logic [19:0] step_reg;
    logic [15:0] chunk_reg;
    cfg_t        cfg;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    q_entry_t    q_in;
    q_entry_t    q_out;
    logic [2:0]  out_ch;
    logic        out_last;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg     <= 4'd2;
            gain_reg   <= 16'd256;
            mono_reg   <= 1'b1;
            resamp_reg <= 1'b0;
            step_reg   <= 20'd65536;
            chunk_reg  <= 16'd9600;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_CHANNEL_COUNT:   cc_reg     <= cfg_data[3:0];
                REG_GAIN:            gain_reg   <= cfg_data[15:0];
                REG_MONO_ENABLE:     mono_reg   <= cfg_data[0];
                REG_RESAMPLE_ENABLE: resamp_reg <= cfg_data[0];
                REG_SOURCE_STEP:     step_reg   <= cfg_data;
                REG_CHUNK_FRAMES:    chunk_reg  <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // Clamp out-of-range settings.
    always_comb
    begin
        if (cc_reg == 4'd0)
        begin
            cfg.cc = 4'd1;
        end
        else if (cc_reg > 4'(MAX_CHANNELS))
        begin
            cfg.cc = 4'(MAX_CHANNELS);
        end
        else
        begin
            cfg.cc = cc_reg;
        end
        cfg.gain      = gain_reg;
        cfg.mono      = mono_reg;
        cfg.resample  = resamp_reg;
        if (step_reg < STEP_MIN)
        begin
            cfg.step = STEP_MIN;
        end
        else if (step_reg > STEP_MAX)
        begin
            cfg.step = STEP_MAX;
        end
        else
        begin
            cfg.step = step_reg;
        end
        cfg.chunk_len = (chunk_reg == '0) ? 16'd1 : chunk_reg;
        cfg.nout      = mono_reg ? 4'd1 : cfg.cc;
    end

    agdrc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_sample (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    agdrc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    agdrc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_empty       (q_empty),
        .q_data        (q_out),
        .q_pop         (q_pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_sample    (m_axis_tdata),
        .out_channel   (out_ch),
        .out_chunk_end (m_axis_tlast),
        .out_run_last  (out_last)
    );

    assign m_axis_tuser = {out_last, out_ch};

endmodule
